// File: hw/rtl/pid_position_loop_hbridge_defines.svh
// Assertion macros used by the position loop RTL.
// Depends on a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef PID_POSITION_LOOP_HBRIDGE_DEFINES_SVH
`define PID_POSITION_LOOP_HBRIDGE_DEFINES_SVH

`ifndef SYNTH
`define PPLH_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("pplh assertion failed");
`define PPLH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pplh assertion failed");
`else
`define PPLH_ASSERT(label, prop)
`define PPLH_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: hw/rtl/pplh_pkg.sv
// Shared types and constants for the position loop with H-bridge output.
// No dependencies.
package pplh_pkg;

  localparam int unsigned CountW = 16;
  localparam int unsigned GainW  = 16;
  localparam int unsigned LimitW = 16;
  localparam int unsigned IntegW = 24;
  localparam int unsigned FracW  = 8;
  localparam int unsigned FwdW   = 15;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [GainW-1:0]         PropGainRst  = 16'd12851;
  localparam logic [GainW-1:0]         IntegGainRst = 16'd0;
  localparam logic [GainW-1:0]         DerivGainRst = 16'd393;
  localparam logic signed [LimitW-1:0] LowLimitRst  = -16'sd50;
  localparam logic signed [LimitW-1:0] HighLimitRst = 16'sd50;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INTEG_GAIN = 3'd1,
    REG_DERIV_GAIN = 3'd2,
    REG_LOW_LIMIT  = 3'd3,
    REG_HIGH_LIMIT = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [GainW-1:0]         prop_gain;
    logic [GainW-1:0]         integral_gain_times_period;
    logic [GainW-1:0]         deriv_gain_over_period;
    logic signed [LimitW-1:0] drive_low_limit;
    logic signed [LimitW-1:0] drive_high_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [IntegW-1:0] integrator;
    logic signed [CountW-1:0] drive_value;
    logic [FwdW-1:0]          forward_duty;
    logic [CountW-1:0]        reverse_duty;
  } result_t;

endpackage

// File: hw/rtl/pplh_cfg.sv
// Configuration register file for the position loop.
// Depends on pplh_pkg.
module pplh_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pplh_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [pplh_pkg::GainW-1:0]      cfg_data,
  output pplh_pkg::cfg_t                  cfg
);
  import pplh_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_PROP_GAIN:  cfg_nxt.prop_gain = cfg_data;
        REG_INTEG_GAIN: cfg_nxt.integral_gain_times_period = cfg_data;
        REG_DERIV_GAIN: cfg_nxt.deriv_gain_over_period = cfg_data;
        REG_LOW_LIMIT:  cfg_nxt.drive_low_limit = $signed(cfg_data);
        REG_HIGH_LIMIT: cfg_nxt.drive_high_limit = $signed(cfg_data);
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain <= PropGainRst;
      cfg_r.integral_gain_times_period <= IntegGainRst;
      cfg_r.deriv_gain_over_period <= DerivGainRst;
      cfg_r.drive_low_limit <= LowLimitRst;
      cfg_r.drive_high_limit <= HighLimitRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: hw/rtl/pplh_law.sv
// Combinational control law: error, clamped integrator, derivative on measurement,
// output clamp, truncation toward zero and bridge split. Depends on pplh_pkg.
module pplh_law (
  input  pplh_pkg::cfg_t                     cfg,
  input  logic [pplh_pkg::CountW-1:0]        target_count,
  input  logic [pplh_pkg::CountW-1:0]        measured_count,
  input  logic [pplh_pkg::CountW-1:0]        prev_measured,
  input  logic signed [pplh_pkg::IntegW-1:0] integrator,
  output pplh_pkg::result_t                  res
);
  import pplh_pkg::*;

  localparam int unsigned DiffW = CountW + 1;
  localparam int unsigned ProdW = GainW + 1 + DiffW;
  localparam int unsigned SumW  = ProdW + 2;

  function automatic logic signed [IntegW-1:0] clamp_lim(
    input logic signed [SumW-1:0]   v,
    input logic signed [LimitW-1:0] lo,
    input logic signed [LimitW-1:0] hi
  );
    logic signed [IntegW-1:0] lo_s;
    logic signed [IntegW-1:0] hi_s;
    lo_s = {lo, {FracW{1'b0}}};
    hi_s = {hi, {FracW{1'b0}}};
    if (v > SumW'(hi_s)) begin
      clamp_lim = hi_s;
    end else if (v < SumW'(lo_s)) begin
      clamp_lim = lo_s;
    end else begin
      clamp_lim = v[IntegW-1:0];
    end
  endfunction

  logic signed [DiffW-1:0]  err;
  logic signed [DiffW-1:0]  dmeas;
  logic signed [ProdW-1:0]  p_term;
  logic signed [ProdW-1:0]  i_term;
  logic signed [ProdW-1:0]  d_term;
  logic signed [SumW-1:0]   integ_sum;
  logic signed [IntegW-1:0] integ_new;
  logic signed [SumW-1:0]   total;
  logic signed [IntegW-1:0] total_cl;
  logic signed [IntegW-1:0] rounded;
  logic signed [CountW-1:0] drive;

  always_comb begin
    err = $signed({1'b0, target_count}) - $signed({1'b0, measured_count});
    dmeas = $signed({1'b0, measured_count}) - $signed({1'b0, prev_measured});
    p_term = $signed({1'b0, cfg.prop_gain}) * err;
    i_term = $signed({1'b0, cfg.integral_gain_times_period}) * err;
    d_term = $signed({1'b0, cfg.deriv_gain_over_period}) * dmeas;

    integ_sum = SumW'(integrator) + SumW'(i_term);
    integ_new = clamp_lim(integ_sum, cfg.drive_low_limit, cfg.drive_high_limit);

    total = SumW'(p_term) + SumW'(integ_new) - SumW'(d_term);
    total_cl = clamp_lim(total, cfg.drive_low_limit, cfg.drive_high_limit);

    // Adding 255 before the arithmetic shift truncates negative values toward zero.
    rounded = total_cl + (total_cl[IntegW-1] ? IntegW'(255) : IntegW'(0));
    drive = CountW'(rounded >>> FracW);

    res.integrator = integ_new;
    res.drive_value = drive;
    res.forward_duty = (drive > 0) ? drive[FwdW-1:0] : '0;
    res.reverse_duty = (drive > 0) ? '0 : CountW'(-drive);
  end

endmodule

// File: hw/rtl/pid_position_loop_hbridge.sv
// Top level of the position PID loop with H-bridge duty output.
// Depends on pplh_pkg, pplh_cfg, pplh_law and pid_position_loop_hbridge_defines.svh.
//
// Usage:
// The input channel carries one beat per control period: target_count in
// in_tdata[15:0] and measured_count in in_tdata[31:16]. Each input beat
// produces exactly one output beat with drive_value, forward_duty and
// reverse_duty. Configuration writes use cfg_valid/cfg_ready with a register
// index and 16-bit data; they are always accepted and should be issued only
// while no beat is in flight. Unknown indexes are ignored.
// A beat is captured in an input register, the control law is evaluated
// combinationally, and the result lands in an output register, from which
// it is offered. One beat per cycle is sustained while the receiver does
// not stall; the integrator and last measurement are registered together
// with the output. When the receiver stalls, the output register holds its
// beat and the input register fills; in_tready falls only when both are
// occupied. Reset clears the integrator, the last measurement, both registers'
// valid flags and loads the default gains and limits.
module pid_position_loop_hbridge (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // target_count [15:0], measured_count [31:16]
  input  logic [31:0]                  in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // drive_value [15:0], forward_duty [30:16], reverse_duty [46:31], zero [47]
  output logic [47:0]                  out_tdata,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [pplh_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [pplh_pkg::GainW-1:0]   cfg_data
);
  import pplh_pkg::*;
  `include "pid_position_loop_hbridge_defines.svh"

  cfg_t    cfg;
  result_t res;

  logic                     s0_valid_r;
  logic [CountW-1:0]        s0_target_r;
  logic [CountW-1:0]        s0_meas_r;
  logic                     out_valid_r;
  logic signed [CountW-1:0] drive_r;
  logic [FwdW-1:0]          fwd_r;
  logic [CountW-1:0]        rev_r;
  logic signed [IntegW-1:0] integ_r;
  logic [CountW-1:0]        prev_meas_r;
  logic                     advance;
  logic                     in_take;

  pplh_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pplh_law u_law (
    .cfg            (cfg),
    .target_count   (s0_target_r),
    .measured_count (s0_meas_r),
    .prev_measured  (prev_meas_r),
    .integrator     (integ_r),
    .res            (res)
  );

  assign advance   = s0_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s0_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      integ_r     <= '0;
      prev_meas_r <= '0;
    end else begin
      if (in_take) begin
        s0_valid_r <= 1'b1;
      end else if (advance) begin
        s0_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        integ_r     <= res.integrator;
        prev_meas_r <= s0_meas_r;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s0_target_r <= in_tdata[CountW-1:0];
      s0_meas_r   <= in_tdata[2*CountW-1:CountW];
    end
    if (advance) begin
      drive_r <= res.drive_value;
      fwd_r   <= res.forward_duty;
      rev_r   <= res.reverse_duty;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, rev_r, fwd_r, drive_r};

  `PPLH_ASSERT(a_duty_exclusive, !out_valid_r || fwd_r == '0 || rev_r == '0)
  `PPLH_ASSERT(a_fwd_matches, !(out_valid_r && drive_r > 0) || fwd_r == drive_r[FwdW-1:0])
  `PPLH_ASSERT_NEXT(a_prev_update, advance, prev_meas_r == $past(s0_meas_r))
  `PPLH_ASSERT_NEXT(a_s0_hold, s0_valid_r && !advance, s0_valid_r)

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for pid_position_loop_hbridge: directed and random control periods
// are checked against a cycle-free model of the PID law kept inside this module.
// Depends on pplh_pkg and the RTL of the position loop.
`timescale 1ns / 1ps

module testbench;
  import pplh_pkg::*;

  typedef struct {
    logic signed [15:0] drive_value;
    logic [14:0]        forward_duty;
    logic [15:0]        reverse_duty;
  } bridge_cmd_t;

  localparam int unsigned NumRegs    = REG_HIGH_LIMIT + 1;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned MaxPrinted = 40;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [31:0]         in_tdata   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [47:0]         out_tdata;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index  = '0;
  logic [GainW-1:0]    cfg_data   = '0;

  cfg_t        loop_cfg = '{PropGainRst, IntegGainRst, DerivGainRst, LowLimitRst, HighLimitRst};
  longint      integ_acc = 0;
  logic [15:0] last_meas = '0;
  bridge_cmd_t expected_cmds[$];

  bit idle_on = 1'b1;
  int fail_count = 0;
  int results_seen = 0;
  int cycle_count = 0;
  int stall_left = 0;

  pid_position_loop_hbridge DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clamp_to_drive_limits(longint v);
    longint hi;
    longint lo;
    hi = longint'($signed(loop_cfg.drive_high_limit)) * 256;
    lo = longint'($signed(loop_cfg.drive_low_limit)) * 256;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Advances the loop state by one control period and returns the bridge command.
  function automatic bridge_cmd_t predict_bridge_cmd(logic [15:0] target, logic [15:0] meas);
    bridge_cmd_t cmd;
    longint      err;
    longint      dmeas;
    longint      sum;
    longint      drive;
    err   = longint'(target) - longint'(meas);
    dmeas = longint'(meas) - longint'(last_meas);
    integ_acc = clamp_to_drive_limits(
        integ_acc + longint'(loop_cfg.integral_gain_times_period) * err);
    sum = longint'(loop_cfg.prop_gain) * err + integ_acc
        - longint'(loop_cfg.deriv_gain_over_period) * dmeas;
    sum = clamp_to_drive_limits(sum);
    drive = sum / 256;
    last_meas = meas;
    cmd.drive_value  = drive[15:0];
    cmd.forward_duty = (drive > 0) ? drive[14:0] : '0;
    cmd.reverse_duty = (drive > 0) ? '0 : 16'(-drive);
    return cmd;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    if (fail_count < MaxPrinted)
      $display("mismatch on %s at result %0d: got %0d, expected %0d",
               field, results_seen, got, want);
    fail_count++;
  endtask

  task automatic send_sample(logic [15:0] target, logic [15:0] meas);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {meas, target};
    do @(posedge clk); while (!in_tready);
    expected_cmds.push_back(predict_bridge_cmd(target, meas));
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PROP_GAIN:  loop_cfg.prop_gain = data;
      REG_INTEG_GAIN: loop_cfg.integral_gain_times_period = data;
      REG_DERIV_GAIN: loop_cfg.deriv_gain_over_period = data;
      REG_LOW_LIMIT:  loop_cfg.drive_low_limit = data;
      REG_HIGH_LIMIT: loop_cfg.drive_high_limit = data;
      default: ;
    endcase
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_settings(logic [15:0] prop, logic [15:0] integ, logic [15:0] deriv,
                                logic [15:0] low, logic [15:0] high);
    drain_results();
    write_reg(REG_PROP_GAIN, prop);
    write_reg(REG_INTEG_GAIN, integ);
    write_reg(REG_DERIV_GAIN, deriv);
    write_reg(REG_LOW_LIMIT, low);
    write_reg(REG_HIGH_LIMIT, high);
    cfg_valid <= 1'b0;
  endtask

  // The first sample after reset sees a previous measurement of zero.
  task automatic test_reset_defaults();
    send_sample(16'd100, 16'd40);
    send_sample(16'd0, 16'd0);
    send_sample(16'hFFFF, 16'd0);
    send_sample(16'd0, 16'hFFFF);
    send_sample(16'hFFFF, 16'hFFFF);
    send_sample(16'd5, 16'd3);
  endtask

  task automatic test_register_extremes();
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF);
    send_sample(16'hFFFF, 16'd0);
    send_sample(16'd0, 16'hFFFF);
    send_sample(16'hFFFF, 16'hFFFF);
    // Integral only, so the integrator winds into both limits.
    apply_settings(16'd0, 16'hFFFF, 16'd0, 16'h8000, 16'h7FFF);
    send_sample(16'hFFFF, 16'd0);
    send_sample(16'hFFFF, 16'd0);
    send_sample(16'd0, 16'hFFFF);
    send_sample(16'd0, 16'hFFFF);
    send_sample(16'd0, 16'd0);
    apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_sample(16'hFFFF, 16'd1);
    send_sample(16'd1, 16'hFFFF);
  endtask

  // With the low limit above the high limit, values above the high limit clamp to it and all others to the low limit.
  task automatic test_inverted_limits();
    apply_settings(16'd256, 16'd16, 16'd0, 16'd100, 16'hFF9C);
    send_sample(16'd1000, 16'd0);
    send_sample(16'd0, 16'd0);
    send_sample(16'd0, 16'd1000);
    send_sample(16'd50, 16'd0);
  endtask

  // Writes to indexes past the last register must leave the settings alone.
  task automatic test_unused_index();
    drain_results();
    for (int i = NumRegs; i < 2 ** CfgIdxW; i++)
      write_reg(CfgIdxW'(i), 16'($urandom));
    cfg_valid <= 1'b0;
    send_sample(16'd2000, 16'd1990);
    send_sample(16'd10, 16'd4000);
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 255));
      2: return 16'($urandom_range(0, 4095));
      default: return 16'($urandom_range(256, 16383));
    endcase
  endfunction

  function automatic logic signed [15:0] pick_limit();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: return 16'(int'($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  task automatic run_samples(int count);
    logic [15:0] target;
    logic [15:0] meas;
    int          diff;
    target = 16'($urandom);
    meas   = 16'($urandom);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 3) begin
        send_sample(16'($urandom), 16'($urandom));
      end else begin
        if ($urandom_range(0, 19) == 0) target = 16'($urandom);
        diff = int'(target) - int'(meas);
        meas = meas + 16'(diff / 4 + int'($urandom_range(0, 128)) - 64);
        send_sample(target, meas);
      end
    end
  endtask

  task automatic test_random_settings();
    logic signed [15:0] low;
    logic signed [15:0] high;
    logic signed [15:0] swap;
    for (int phase = 0; phase < 8; phase++) begin
      low  = pick_limit();
      high = pick_limit();
      if (low > high && $urandom_range(0, 9) < 7) begin
        swap = low;
        low  = high;
        high = swap;
      end
      apply_settings(pick_gain(), pick_gain(), pick_gain(), low, high);
      if (phase == 7) idle_on = 1'b0;
      run_samples(phase == 7 ? 200 : 135);
    end
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      if (stall_left == 0) out_tready <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 12);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    bridge_cmd_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_cmds.size() == 0) begin
        report_mismatch("result with nothing expected", out_tdata[15:0], 0);
      end else begin
        want = expected_cmds.pop_front();
        if (out_tdata[15:0] !== want.drive_value)
          report_mismatch("drive_value", $signed(out_tdata[15:0]), want.drive_value);
        if (out_tdata[30:16] !== want.forward_duty)
          report_mismatch("forward_duty", out_tdata[30:16], want.forward_duty);
        if (out_tdata[46:31] !== want.reverse_duty)
          report_mismatch("reverse_duty", out_tdata[46:31], want.reverse_duty);
        if (out_tdata[47] !== 1'b0)
          report_mismatch("padding bit", out_tdata[47], 0);
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_register_extremes();
    test_inverted_limits();
    test_unused_index();
    test_random_settings();
    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && expected_cmds.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/pplh_pkg.sv
hw/rtl/pplh_cfg.sv
hw/rtl/pplh_law.sv
hw/rtl/pid_position_loop_hbridge.sv
tb/sv/testbench.sv
